FILE: rtl/ilpm_pkg.sv
`default_nettype none
package ilpm_pkg;

   localparam int TS_W      = 64;
   localparam int US_W      = 32;
   localparam int TOTAL_W   = 48;
   localparam int FIELD10_W = 10;
   localparam int DSR_W     = 13;
   localparam int DIV_CNT_W = 6;
   localparam int PCT_W     = 7;

   // ns to us conversion, one 14-bit dividend digit at a time
   localparam int CHUNK_W       = 14;
   localparam int REM_W         = 10;
   localparam int MV_W          = REM_W + CHUNK_W;
   localparam int MQ_W          = 42;
   localparam int MARK_STEP_W   = 3;
   localparam int RECIP_1000_W  = 25;
   localparam int RECIP_1000_SH = 34;
   localparam int MPROD_W       = MV_W + RECIP_1000_W;
   localparam int RECIP_100_W   = 19;
   localparam int RECIP_100_SH  = 25;

   localparam logic [DSR_W-1:0] NS_PER_US  = DSR_W'(1000);
   localparam logic [PCT_W-1:0] RANK_ROUND = PCT_W'(99);
   localparam logic [PCT_W-1:0] PCT_P50    = PCT_W'(50);
   localparam logic [PCT_W-1:0] PCT_P95    = PCT_W'(95);
   localparam logic [PCT_W-1:0] PCT_P99    = PCT_W'(99);

   // ceil(2^sh / d), exact over the operand ranges used
   localparam logic [RECIP_1000_W-1:0] RECIP_1000  = RECIP_1000_W'(17179870);
   localparam logic [RECIP_100_W-1:0]  RECIP_100   = RECIP_100_W'(335545);
   localparam logic [MARK_STEP_W-1:0]  MARK_COMMIT = MARK_STEP_W'(6);

   typedef enum logic [1:0] {
      REQ_MARK   = 2'd0,
      REQ_REPORT = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } ilpm_op_type;

   typedef enum logic [1:0] {
      SEL_P50 = 2'd0,
      SEL_P95 = 2'd1,
      SEL_P99 = 2'd2,
      SEL_END = 2'd3
   } ilpm_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK_WAIT,
      ST_RANK_GO,
      ST_RANK_WAIT,
      ST_SCAN,
      ST_SCAN_END,
      ST_SCAN_UPD,
      ST_MEAN_WAIT
   } ilpm_state_type;

   typedef struct packed {
      logic [1:0]      req_type;
      logic [TS_W-1:0] timestamp_ns;
   } ilpm_req_type;

   typedef struct packed {
      logic                 valid_res;
      logic [FIELD10_W-1:0] sample_count;
      logic [TOTAL_W-1:0]   total_written;
      logic [US_W-1:0]      p50_us;
      logic [US_W-1:0]      p95_us;
      logic [US_W-1:0]      p99_us;
      logic [US_W-1:0]      max_us;
      logic [US_W-1:0]      mean_us;
      logic [FIELD10_W-1:0] window_over_budget;
      logic [US_W-1:0]      lifetime_over_budget;
      logic [US_W-1:0]      generation;
      logic [TS_W-1:0]      session_span_ns;
   } ilpm_rsp_type;

   typedef struct packed {
      logic             start;
      logic [TS_W-1:0]  dividend;
      logic [DSR_W-1:0] divisor;
   } ilpm_div_req_type;

   typedef struct packed {
      logic            done;
      logic [TS_W-1:0] quotient;
   } ilpm_div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/ilpm_div.sv
`default_nettype none
module ilpm_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ilpm_pkg::ilpm_div_req_type  div_req,
   output ilpm_pkg::ilpm_div_rsp_type       div_rsp
);
   import ilpm_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TS_W-1:0]      quo_ff, quo_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W:0]       trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[TS_W-1]};
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '1;
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
      end else if (run_ff) begin
         // restoring step, one quotient bit per cycle
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DSR_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[TS_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DSR_W-1:0];
            quo_in = {quo_ff[TS_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/ilpm_ram.sv
`default_nettype none
module ilpm_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/interval_latency_percentile_monitor_unit.sv
`default_nettype none
// interval latency percentile monitor
// request channel: start with req_data; a transaction is taken when start is
// high and busy is low. req_type selects mark, report or clear; code 3 is
// ignored. result channel: one report gives one transaction on rsp_data, held
// for exactly one cycle under rsp_valid; the receiver cannot stall it.
// csr_wr_en/csr_wr_data write budget_us; write only while busy is low.
// busy behaviour by request:
//   clear, ignored code, mark with no origin or time not moving forward: busy
//   stays low, the next transaction can be taken on the following cycle
//   mark that records an interval: busy while it converts and writes;
//   ns to us by reciprocal multiply over three 14-bit digits, then write
//   report on an empty window: result in the cycle after acceptance
//   report: busy for three rank steps, 32 radix-select sweeps over the
//   window memory (one read per cycle) and a 64-step mean division
// a report's result is on rsp_data in the first cycle busy is low.
// reset clears the written and over-budget counters, marks and the generation; window memory needs
// no clearing since only entries written since the last clear are read.
module interval_latency_percentile_monitor_unit #(
   parameter int WINDOW_DEPTH = 512
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire ilpm_pkg::ilpm_req_type  req_data,
   output logic                         rsp_valid,
   output ilpm_pkg::ilpm_rsp_type       rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [31:0]             csr_wr_data
);
   import ilpm_pkg::*;

   localparam int AW      = $clog2(WINDOW_DEPTH);
   localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W   = US_W + CNT_W;
   localparam int NUM_W   = CNT_W + PCT_W;
   localparam int RPROD_W = NUM_W + RECIP_100_W;

   ilpm_state_type state_ff, state_in;
   logic [US_W-1:0]    budget_ff;
   logic [TS_W-1:0]    prev_ff, prev_in;
   logic [TS_W-1:0]    first_ff, first_in;
   logic [TS_W-1:0]    last_ff, last_in;
   logic [TOTAL_W-1:0] written_ff, written_in;
   logic [US_W-1:0]    over_ff, over_in;
   logic [US_W-1:0]    gen_ff, gen_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rank_ff [3];
   logic [CNT_W-1:0]   rank_in [3];
   logic [US_W-1:0]    prefix_ff [3];
   logic [US_W-1:0]    prefix_in [3];
   logic [CNT_W-1:0]   cnt0_ff [3];
   logic [CNT_W-1:0]   cnt0_in [3];
   logic [US_W-1:0]    onehot_ff, onehot_in;
   logic [US_W-1:0]    mask_ff, mask_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               rdv_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [US_W-1:0]    max_ff, max_in;
   logic [CNT_W-1:0]   above_ff, above_in;
   ilpm_sel_type       sel_ff, sel_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ilpm_rsp_type       rsp_ff, rsp_in;
   logic [NUM_W-1:0]   rnum_ff, rnum_in;
   logic [TS_W-1:0]        mdvd_ff, mdvd_in;
   logic [REM_W-1:0]       mrem_ff, mrem_in;
   logic [MV_W-1:0]        mv_ff, mv_in;
   logic [CHUNK_W-1:0]     mq_ff, mq_in;
   logic [MQ_W-1:0]        mquo_ff, mquo_in;
   logic                   msat_ff, msat_in;
   logic [MARK_STEP_W-1:0] mstep_ff, mstep_in;

   ilpm_div_req_type   div_req;
   ilpm_div_rsp_type   div_rsp;
   logic               wr_en;
   logic [US_W-1:0]    wr_data;
   logic [US_W-1:0]    rd_data;
   logic               accept;
   logic [PCT_W-1:0]   pct;
   logic [NUM_W-1:0]   rank_num;
   logic [RPROD_W-1:0] rank_prod;
   logic [TS_W-1:0]    span;
   logic [MV_W-1:0]    mv_next;
   logic [MPROD_W-1:0] mprod;
   logic [MV_W-1:0]    mrem_next;
   logic               mark_sat;

   ilpm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ilpm_ram #(
      .DEPTH (WINDOW_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (wr_data),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign span   = (last_ff > first_ff) ? (last_ff - first_ff) : '0;

   always_comb begin
      case (sel_ff)
         SEL_P50: pct = PCT_P50;
         SEL_P95: pct = PCT_P95;
         SEL_P99: pct = PCT_P99;
         default: pct = PCT_P99;
      endcase
   end

   assign rank_num  = NUM_W'(count_ff) * NUM_W'(pct) + NUM_W'(RANK_ROUND);
   assign rank_prod = RPROD_W'(rnum_ff) * RPROD_W'(RECIP_100);

   // long division by 1000, remainder carried between digits
   assign mv_next   = {mrem_ff, mdvd_ff[MQ_W-1 -: CHUNK_W]};
   assign mprod     = MPROD_W'(mv_next) * MPROD_W'(RECIP_1000);
   assign mrem_next = mv_ff - MV_W'(mq_ff) * MV_W'(NS_PER_US);
   assign mark_sat  = msat_ff | (|mquo_ff[MQ_W-1:US_W]);

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      written_in   = written_ff;
      over_in      = over_ff;
      gen_in       = gen_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      rank_in      = rank_ff;
      prefix_in    = prefix_ff;
      cnt0_in      = cnt0_ff;
      onehot_in    = onehot_ff;
      mask_in      = mask_ff;
      addr_in      = addr_ff;
      sum_in       = sum_ff;
      max_in       = max_ff;
      above_in     = above_ff;
      sel_in       = sel_ff;
      rnum_in      = rnum_ff;
      mdvd_in      = mdvd_ff;
      mrem_in      = mrem_ff;
      mv_in        = mv_ff;
      mq_in        = mq_ff;
      mquo_in      = mquo_ff;
      msat_in      = msat_ff;
      mstep_in     = mstep_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_req      = '0;
      wr_en        = 1'b0;
      wr_data      = mark_sat ? '1 : mquo_ff[US_W-1:0];

      // sample arriving from the window memory
      if (rdv_ff) begin
         for (int k = 0; k < 3; k++) begin
            if ((((rd_data ^ prefix_ff[k]) & mask_ff) == '0) && ((rd_data & onehot_ff) == '0)) begin
               cnt0_in[k] = cnt0_ff[k] + 1'b1;
            end
         end
         if (onehot_ff[US_W-1]) begin
            sum_in = sum_ff + SUM_W'(rd_data);
            if (rd_data > max_ff) begin
               max_in = rd_data;
            end
            if ((budget_ff != '0) && (rd_data > budget_ff)) begin
               above_in = above_ff + 1'b1;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_MARK: begin
                     prev_in = req_data.timestamp_ns;
                     last_in = req_data.timestamp_ns;
                     if (prev_ff == '0) begin
                        first_in = req_data.timestamp_ns;
                     end else if (req_data.timestamp_ns > prev_ff) begin
                        mdvd_in  = req_data.timestamp_ns - prev_ff;
                        mrem_in  = '0;
                        mstep_in = '0;
                        state_in = ST_MARK_WAIT;
                     end
                  end
                  REQ_REPORT: begin
                     if (written_ff == '0) begin
                        rsp_valid_in                = 1'b1;
                        rsp_in                      = '0;
                        rsp_in.lifetime_over_budget = over_ff;
                        rsp_in.generation           = gen_ff;
                        rsp_in.session_span_ns      = span;
                     end else begin
                        count_in  = (written_ff < TOTAL_W'(WINDOW_DEPTH)) ?
                                    CNT_W'(written_ff) : CNT_W'(WINDOW_DEPTH);
                        sel_in    = SEL_P50;
                        onehot_in = {1'b1, {(US_W-1){1'b0}}};
                        mask_in   = '0;
                        addr_in   = '0;
                        sum_in    = '0;
                        max_in    = '0;
                        above_in  = '0;
                        for (int k = 0; k < 3; k++) begin
                           prefix_in[k] = '0;
                           cnt0_in[k]   = '0;
                        end
                        state_in  = ST_RANK_GO;
                     end
                  end
                  REQ_CLEAR: begin
                     prev_in    = '0;
                     first_in   = '0;
                     last_in    = '0;
                     written_in = '0;
                     over_in    = '0;
                     ptr_in     = '0;
                     gen_in     = gen_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MARK_WAIT: begin
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == MARK_COMMIT) begin
               wr_en  = 1'b1;
               ptr_in = (ptr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
               if (written_ff != '1) begin
                  written_in = written_ff + 1'b1;
               end
               if ((budget_ff != '0) && (mark_sat || (mquo_ff[US_W-1:0] > budget_ff)) &&
                   (over_ff != '1)) begin
                  over_in = over_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end else if (!mstep_ff[0]) begin
               // quotient digit from the reciprocal product
               mv_in = mv_next;
               mq_in = mprod[RECIP_1000_SH +: CHUNK_W];
               if (mstep_ff == '0) begin
                  msat_in = |mdvd_ff[TS_W-1:MQ_W];
               end
            end else begin
               mrem_in = mrem_next[REM_W-1:0];
               mquo_in = {mquo_ff[MQ_W-CHUNK_W-1:0], mq_ff};
               mdvd_in = mdvd_ff << CHUNK_W;
            end
         end
         ST_RANK_GO: begin
            rnum_in  = rank_num;
            state_in = ST_RANK_WAIT;
         end
         ST_RANK_WAIT: begin
            // ceil(count*p/100) lies in 1..count for these percentiles
            rank_in[sel_ff] = rank_prod[RECIP_100_SH +: CNT_W] - 1'b1;
            if (sel_ff == SEL_P99) begin
               state_in = ST_SCAN;
            end else begin
               sel_in   = ilpm_sel_type'(sel_ff + 1'b1);
               state_in = ST_RANK_GO;
            end
         end
         ST_SCAN: begin
            if (CNT_W'(addr_ff) == count_ff - 1'b1) begin
               addr_in  = '0;
               state_in = ST_SCAN_END;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_SCAN_UPD;
         end
         ST_SCAN_UPD: begin
            // decide one bit of each selected value per sweep, msb first
            for (int k = 0; k < 3; k++) begin
               if (rank_ff[k] >= cnt0_ff[k]) begin
                  prefix_in[k] = prefix_ff[k] | onehot_ff;
                  rank_in[k]   = rank_ff[k] - cnt0_ff[k];
               end
               cnt0_in[k] = '0;
            end
            mask_in   = mask_ff | onehot_ff;
            onehot_in = onehot_ff >> 1;
            if (onehot_ff[0]) begin
               div_req.start    = 1'b1;
               div_req.dividend = TS_W'(sum_ff);
               div_req.divisor  = DSR_W'(count_ff);
               state_in         = ST_MEAN_WAIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               rsp_valid_in                = 1'b1;
               rsp_in.valid_res            = 1'b1;
               rsp_in.sample_count         = FIELD10_W'(count_ff);
               rsp_in.total_written        = written_ff;
               rsp_in.p50_us               = prefix_ff[0];
               rsp_in.p95_us               = prefix_ff[1];
               rsp_in.p99_us               = prefix_ff[2];
               rsp_in.max_us               = max_ff;
               rsp_in.mean_us              = div_rsp.quotient[US_W-1:0];
               rsp_in.window_over_budget   = FIELD10_W'(above_ff);
               rsp_in.lifetime_over_budget = over_ff;
               rsp_in.generation           = gen_ff;
               rsp_in.session_span_ns      = span;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         budget_ff    <= '0;
         prev_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         written_ff   <= '0;
         over_ff      <= '0;
         gen_ff       <= '0;
         ptr_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         written_ff   <= written_in;
         over_ff      <= over_in;
         gen_ff       <= gen_in;
         ptr_ff       <= ptr_in;
         rdv_ff       <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff  <= count_in;
      rank_ff   <= rank_in;
      prefix_ff <= prefix_in;
      cnt0_ff   <= cnt0_in;
      onehot_ff <= onehot_in;
      mask_ff   <= mask_in;
      addr_ff   <= addr_in;
      sum_ff    <= sum_in;
      max_ff    <= max_in;
      above_ff  <= above_in;
      sel_ff    <= sel_in;
      rsp_ff    <= rsp_in;
      rnum_ff   <= rnum_in;
      mdvd_ff   <= mdvd_in;
      mrem_ff   <= mrem_in;
      mv_ff     <= mv_in;
      mq_ff     <= mq_in;
      mquo_ff   <= mquo_in;
      msat_ff   <= msat_in;
      mstep_ff  <= mstep_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MEAN_WAIT))
      else $error("divider finished with no one waiting");
   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(addr_ff) < count_ff))
      else $error("window read beyond sample count");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= AW'(WINDOW_DEPTH - 1))
      else $error("ring pointer out of range");
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.valid_res) |-> $past(state_ff == ST_MEAN_WAIT))
      else $error("report result without mean division");
`endif

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
module tb;
   import ilpm_pkg::*;

   localparam int DEPTH = 512;

   typedef struct {
      ilpm_op_type  op;
      logic [63:0]  ts;
      bit           typed;
      ilpm_rsp_type rsp;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   ilpm_req_type req_data = '0;
   logic         rsp_valid;
   ilpm_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   // predictor state
   logic [31:0] win_us [DEPTH];
   logic [47:0] marks_written;
   logic [63:0] prev_ns, first_ns, last_ns;
   logic [31:0] over_total, clear_gen, budget;
   int          ring_wr;

   ilpm_rsp_type report_q[$];
   int          errors = 0;
   int          idle_pct = 0;
   int          n_items = 0;
   logic [63:0] cur_ts = '0;

   interval_latency_percentile_monitor_unit #(.WINDOW_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned rank_of(int unsigned cnt, int unsigned pct);
      longint unsigned r;
      r = (longint'(cnt) * pct + 99) / 100;
      if (r == 0) r = 1;
      if (r > cnt) r = cnt;
      return r - 1;
   endfunction

   function automatic ilpm_rsp_type window_stats();
      ilpm_rsp_type    r;
      logic [31:0]     srt[$];
      longint unsigned sum;
      int unsigned     cnt, above;
      r = '0;
      sum = 0;
      above = 0;
      r.lifetime_over_budget = over_total;
      r.generation = clear_gen;
      r.session_span_ns = (last_ns > first_ns) ? last_ns - first_ns : '0;
      if (marks_written == 0) return r;
      cnt = (marks_written < DEPTH) ? int'(marks_written) : DEPTH;
      for (int i = 0; i < cnt; i++) begin
         srt.push_back(win_us[i]);
         sum += win_us[i];
         if (budget != 0 && win_us[i] > budget) above++;
      end
      srt.sort();
      r.valid_res = 1'b1;
      r.sample_count = cnt[9:0];
      r.total_written = marks_written;
      r.p50_us = srt[rank_of(cnt, 50)];
      r.p95_us = srt[rank_of(cnt, 95)];
      r.p99_us = srt[rank_of(cnt, 99)];
      r.max_us = srt[cnt-1];
      r.mean_us = 32'(sum / cnt);
      r.window_over_budget = above[9:0];
      return r;
   endfunction

   task automatic clear_state();
      foreach (win_us[i]) win_us[i] = '0;
      marks_written = '0;
      prev_ns = '0;
      first_ns = '0;
      last_ns = '0;
      over_total = '0;
      ring_wr = 0;
   endtask

   task automatic apply_mark(logic [63:0] ts);
      logic [63:0] prv, us;
      prv = prev_ns;
      prev_ns = ts;
      last_ns = ts;
      if (prv == 0) begin
         first_ns = ts;
      end else if (ts > prv) begin
         us = (ts - prv) / 64'd1000;
         win_us[ring_wr] = (us > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : us[31:0];
         ring_wr = (ring_wr + 1) % DEPTH;
         if (marks_written != '1) marks_written++;
         if (budget != 0 && us > {32'd0, budget} && over_total != '1) over_total++;
      end
   endtask

   // drive one transaction; the predictor is updated at the edge that takes it
   task automatic send(ilpm_op_type op, logic [63:0] ts, bit typed, ilpm_rsp_type rsp);
      ilpm_req_type r;
      r.req_type = op;
      r.timestamp_ns = ts;
      start <= 1'b1;
      req_data <= r;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      case (op)
         REQ_MARK:   apply_mark(ts);
         REQ_REPORT: report_q.push_back(typed ? rsp : window_stats());
         REQ_CLEAR:  begin clear_state(); clear_gen++; end
         default:    ;
      endcase
      if (op != REQ_NONE) n_items++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic go(ilpm_op_type op, logic [63:0] ts);
      send(op, ts, 1'b0, '0);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (busy || report_q.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_budget(logic [31:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      budget = v;
      @(posedge clock);
   endtask

   task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      ilpm_rsp_type e;
      if (!reset && rsp_valid) begin
         if (report_q.size() == 0) begin
            $display("%0t: unexpected report transaction %h", $time, rsp_data);
            errors++;
         end else begin
            e = report_q.pop_front();
            cmp("valid_res", e.valid_res, rsp_data.valid_res);
            cmp("sample_count", e.sample_count, rsp_data.sample_count);
            cmp("total_written", e.total_written, rsp_data.total_written);
            cmp("p50_us", e.p50_us, rsp_data.p50_us);
            cmp("p95_us", e.p95_us, rsp_data.p95_us);
            cmp("p99_us", e.p99_us, rsp_data.p99_us);
            cmp("max_us", e.max_us, rsp_data.max_us);
            cmp("mean_us", e.mean_us, rsp_data.mean_us);
            cmp("window_over_budget", e.window_over_budget, rsp_data.window_over_budget);
            cmp("lifetime_over_budget", e.lifetime_over_budget,
                rsp_data.lifetime_over_budget);
            cmp("generation", e.generation, rsp_data.generation);
            cmp("session_span_ns", e.session_span_ns, rsp_data.session_span_ns);
         end
      end
   end

   // next mark time: mostly steady frames, sometimes odd ones
   function automatic logic [63:0] next_ts();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 4) return '0;
      if (pick < 9) return cur_ts - $urandom_range(0, 5_000_000);
      if (pick < 13) return {$urandom, $urandom};
      if (pick < 16) return cur_ts + {$urandom_range(0, 15), $urandom};
      return cur_ts + $urandom_range(0, 4_000_000);
   endfunction

   task automatic mark_run(int n, int report_every);
      for (int i = 1; i <= n; i++) begin
         cur_ts = next_ts();
         go(REQ_MARK, cur_ts);
         if (report_every != 0 && i % report_every == 0) go(REQ_REPORT, '0);
      end
   endtask

   initial begin
      stim_row_type rows[$];
      ilpm_rsp_type gen1;
      logic [31:0] budgets [7];
      gen1 = '0;
      gen1.generation = 32'd1;
      budgets = '{32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd2500, 32'd40, 32'd1800};
      clear_state();
      clear_gen = '0;
      budget = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{REQ_REPORT, 64'd0, 1'b1, '0});
      rows.push_back('{REQ_MARK, 64'd0, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd1000, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd3000, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd2000, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd2000, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd9999, 1'b0, '0});
      rows.push_back('{REQ_REPORT, 64'd0, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd0, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd5000, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
      rows.push_back('{REQ_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
      rows.push_back('{REQ_REPORT, 64'd0, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd7, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd4_000_007, 1'b0, '0});
      rows.push_back('{REQ_REPORT, 64'd0, 1'b0, '0});
      rows.push_back('{REQ_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
      rows.push_back('{REQ_REPORT, 64'd0, 1'b1, gen1});
      rows.push_back('{REQ_MARK, 64'd1, 1'b0, '0});
      rows.push_back('{REQ_MARK, 64'd1_000_001, 1'b0, '0});
      rows.push_back('{REQ_REPORT, 64'd0, 1'b0, '0});
      write_budget(32'd2);
      foreach (rows[i]) send(rows[i].op, rows[i].ts, rows[i].typed, rows[i].rsp);

      for (int ph = 0; ph < 7; ph++) begin
         write_budget(budgets[ph]);
         idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 78 : 17;
         if (ph == 2) begin
            // run more marks than the ring depth; not every mark records an interval
            go(REQ_CLEAR, '0);
            cur_ts = $urandom_range(1, 1000);
            mark_run(600, 150);
            go(REQ_REPORT, '0);
         end
         while (n_items < 200 * (ph + 1)) begin
            if ($urandom_range(9) == 0) begin
               send(ilpm_op_type'($urandom_range(3)), {$urandom, $urandom}, 1'b0, '0);
            end else begin
               if ($urandom_range(3) == 0) go(REQ_CLEAR, {$urandom, $urandom});
               mark_run($urandom_range(1, 24), 0);
               go(REQ_REPORT, {$urandom, $urandom});
            end
         end
      end

      drain();
      if (errors == 0) $display("** interval_latency_percentile_monitor_unit: PASSED **");
      else $display("** interval_latency_percentile_monitor_unit: FAILED **");
      $finish;
   end

   initial begin
      #100ms;
      $display("** interval_latency_percentile_monitor_unit: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ilpm_pkg.sv
rtl/ilpm_div.sv
rtl/ilpm_ram.sv
rtl/interval_latency_percentile_monitor_unit.sv
verif/tb.sv
